/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* rtl/mhpq_pkg.sv */
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int KEY_W            = 32;

    localparam logic signed [KEY_W-1:0] EMPTY_VALUE = {KEY_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_INCREASE = 2'd2,
        OP_PEEK     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_SMALLER = 3'd3,
        STAT_RANGE   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT_RD,
        S_ROOT_CAP,
        S_LAST_CAP,
        S_INC_RD,
        S_INC_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FINISH
    } state_t;

endpackage

/* rtl/mhpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/max_heap_priority_queue.sv */
// Binary max-heap priority queue of signed keys: sequencer, comparator and heap RAM.
//
// Request channel (request_valid / request_stall) carries operation, key_value and
// target_index; the result channel (result_valid / result_stall) returns result_value,
// status and entry_count, exactly one result item per request item.
// One item is worked on at a time: request_stall is high from acceptance until the
// sequencer is back in idle. Every heap read goes through one RAM read port with a
// registered read, and one signed comparator is shared by all steps.
// Steps from acceptance to result_valid (L = levels the entry moves):
//   full, empty or out-of-range request: straight to finish; peek: root read and capture;
//   insert: a parent read and compare per level of L, and a final write of the key;
//   increase-key reads and compares the target first; extract reads the root and the last
//   entry, then each level down reads both children before comparing.
// With CAPACITY = 64, L is at most 6 going up and 5 going down; the next request
// can be taken in the same cycle that result_valid rises.
// The finished result sits in an output register; a new request is taken while it
// waits, and only the final hand-off stalls until result_stall drops.
// Reset empties the heap (count zero) and clears result_valid; heap RAM is not cleared,
// as no entry at or above the count is ever used.
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int CH_W    = IDX_W + 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              request_valid,
    output logic                              request_stall,
    input  logic [1:0]                        operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0] key_value,
    input  logic [IDX_W-1:0]                  target_index,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [mhpq_pkg::KEY_W-1:0] result_value,
    output logic [2:0]                        status,
    output logic [CNT_W-1:0]                  entry_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    mhpq_pkg::state_t  state_reg, state_next;
    mhpq_pkg::op_t     op_reg, op_next;
    mhpq_pkg::status_t res_status_reg, res_status_next;
    mhpq_pkg::status_t out_status_reg, out_status_next;

    logic signed [mhpq_pkg::KEY_W-1:0] key_reg, key_next;
    logic signed [mhpq_pkg::KEY_W-1:0] best_val_reg, best_val_next;
    logic signed [mhpq_pkg::KEY_W-1:0] res_value_reg, res_value_next;
    logic signed [mhpq_pkg::KEY_W-1:0] out_value_reg, out_value_next;
    logic        [IDX_W-1:0]           pos_reg, pos_next;
    logic        [CNT_W-1:0]           count_reg, count_next;
    logic        [CNT_W-1:0]           out_count_reg, out_count_next;
    logic                              best_left_reg, best_left_next;
    logic                              out_valid_reg, out_valid_next;

    logic                              wr_en;
    logic        [IDX_W-1:0]           wr_addr;
    logic        [mhpq_pkg::KEY_W-1:0] wr_data;
    logic        [IDX_W-1:0]           rd_addr;
    logic        [mhpq_pkg::KEY_W-1:0] rd_data;
    logic signed [mhpq_pkg::KEY_W-1:0] rd_key;

    logic signed [mhpq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic                              cmp_gt;

    logic [CH_W-1:0]  left_idx, right_idx;
    logic [IDX_W-1:0] parent_idx;
    logic             right_in;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key = rd_data;

    assign left_idx   = CH_W'({pos_reg, 1'b0}) + CH_W'(1);
    assign right_idx  = left_idx + CH_W'(1);
    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign right_in   = right_idx < CH_W'(count_reg);

    // Shared comparator; sift-up puts the moving key on the left side.
    always_comb
    begin
        cmp_a = rd_key;
        cmp_b = key_reg;
        if (state_reg == mhpq_pkg::S_UP_CMP)
        begin
            cmp_a = key_reg;
            cmp_b = rd_key;
        end
        else if (state_reg == mhpq_pkg::S_DN_CMP)
        begin
            cmp_b = best_val_reg;
        end
    end

    assign cmp_gt = cmp_a > cmp_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhpq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        best_val_reg   <= best_val_next;
        best_left_reg  <= best_left_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // The moving key is held in key_reg; each level writes the entry that passes it
    // into the hole, and the key itself is written once where it stops.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        best_val_next   = best_val_reg;
        best_left_next  = best_left_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        rd_addr         = pos_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;

        case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (request_valid)
                begin
                    op_next         = mhpq_pkg::op_t'(operation);
                    key_next        = key_value;
                    res_value_next  = '0;
                    res_status_next = mhpq_pkg::STAT_OK;
                    case (mhpq_pkg::op_t'(operation))
                        mhpq_pkg::OP_INSERT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                res_status_next = mhpq_pkg::STAT_FULL;
                                state_next      = mhpq_pkg::S_FINISH;
                            end
                            else
                            begin
                                pos_next   = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                state_next = mhpq_pkg::S_UP_RD;
                            end
                        end
                        mhpq_pkg::OP_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_value_next  = mhpq_pkg::EMPTY_VALUE;
                                res_status_next = mhpq_pkg::STAT_EMPTY;
                                state_next      = mhpq_pkg::S_FINISH;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                state_next = mhpq_pkg::S_ROOT_RD;
                            end
                        end
                        mhpq_pkg::OP_INCREASE:
                        begin
                            if (CNT_W'(target_index) >= count_reg)
                            begin
                                res_status_next = mhpq_pkg::STAT_RANGE;
                                state_next      = mhpq_pkg::S_FINISH;
                            end
                            else
                            begin
                                pos_next   = target_index;
                                state_next = mhpq_pkg::S_INC_RD;
                            end
                        end
                        mhpq_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_value_next  = mhpq_pkg::EMPTY_VALUE;
                                res_status_next = mhpq_pkg::STAT_EMPTY;
                                state_next      = mhpq_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = mhpq_pkg::S_ROOT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = mhpq_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            mhpq_pkg::S_ROOT_RD:
            begin
                rd_addr    = '0;
                state_next = mhpq_pkg::S_ROOT_CAP;
            end

            mhpq_pkg::S_ROOT_CAP:
            begin
                res_value_next = rd_key;
                if (op_reg == mhpq_pkg::OP_EXTRACT)
                begin
                    // count already decremented: it now points at the last entry
                    rd_addr    = count_reg[IDX_W-1:0];
                    state_next = mhpq_pkg::S_LAST_CAP;
                end
                else
                begin
                    state_next = mhpq_pkg::S_FINISH;
                end
            end

            mhpq_pkg::S_LAST_CAP:
            begin
                key_next   = rd_key;
                pos_next   = '0;
                state_next = mhpq_pkg::S_DN_RDL;
            end

            mhpq_pkg::S_DN_RDL:
            begin
                if (left_idx >= CH_W'(count_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = mhpq_pkg::S_FINISH;
                end
                else
                begin
                    rd_addr    = left_idx[IDX_W-1:0];
                    state_next = mhpq_pkg::S_DN_RDR;
                end
            end

            mhpq_pkg::S_DN_RDR:
            begin
                // right address may lie past the count; its data is then ignored
                rd_addr = right_idx[IDX_W-1:0];
                if (cmp_gt)
                begin
                    best_val_next  = rd_key;
                    best_left_next = 1'b1;
                end
                else
                begin
                    best_val_next  = key_reg;
                    best_left_next = 1'b0;
                end
                state_next = mhpq_pkg::S_DN_CMP;
            end

            mhpq_pkg::S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (right_in && cmp_gt)
                begin
                    wr_data    = rd_key;
                    pos_next   = right_idx[IDX_W-1:0];
                    state_next = mhpq_pkg::S_DN_RDL;
                end
                else if (best_left_reg)
                begin
                    wr_data    = best_val_reg;
                    pos_next   = left_idx[IDX_W-1:0];
                    state_next = mhpq_pkg::S_DN_RDL;
                end
                else
                begin
                    state_next = mhpq_pkg::S_FINISH;
                end
            end

            mhpq_pkg::S_INC_RD:
            begin
                state_next = mhpq_pkg::S_INC_CMP;
            end

            mhpq_pkg::S_INC_CMP:
            begin
                // equal key is accepted
                if (cmp_gt)
                begin
                    res_status_next = mhpq_pkg::STAT_SMALLER;
                    state_next      = mhpq_pkg::S_FINISH;
                end
                else
                begin
                    state_next = mhpq_pkg::S_UP_RD;
                end
            end

            mhpq_pkg::S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = mhpq_pkg::S_FINISH;
                end
                else
                begin
                    rd_addr    = parent_idx;
                    state_next = mhpq_pkg::S_UP_CMP;
                end
            end

            mhpq_pkg::S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_gt)
                begin
                    wr_data    = rd_key;
                    pos_next   = parent_idx;
                    state_next = mhpq_pkg::S_UP_RD;
                end
                else
                begin
                    state_next = mhpq_pkg::S_FINISH;
                end
            end

            mhpq_pkg::S_FINISH:
            begin
                if (!(out_valid_reg && result_stall))
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    state_next      = mhpq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    assign request_stall = (state_reg != mhpq_pkg::S_IDLE);
    assign result_valid  = out_valid_reg;
    assign result_value  = out_value_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;

endmodule

/* rtl/mhpq_checker.sv */
// Port-level checker for the max-heap priority queue, bound to the top level.
`include "assert_macros.svh"

module mhpq_checker #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              request_valid,
    input logic                              request_stall,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic signed [mhpq_pkg::KEY_W-1:0] result_value,
    input logic [2:0]                        status,
    input logic [CNT_W-1:0]                  entry_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic req_taken;
    logic count_ok;

    assign req_taken = request_valid && !request_stall;
    // a full refusal reports the heap at capacity
    assign count_ok  = (entry_count <= CAP_CNT) &&
                       ((status != mhpq_pkg::STAT_FULL) || (entry_count == CAP_CNT));

    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_value) && $stable(status) && $stable(entry_count))

    `ASSERT_IMPLY(a_empty_result, clk, rst_n, result_valid && (status == mhpq_pkg::STAT_EMPTY), (result_value == mhpq_pkg::EMPTY_VALUE) && (entry_count == '0))

    `ASSERT_IMPLY(a_refused_zero, clk, rst_n, result_valid && ((status == mhpq_pkg::STAT_FULL) || (status == mhpq_pkg::STAT_SMALLER) || (status == mhpq_pkg::STAT_RANGE)), result_value == '0)

    `ASSERT_IMPLY(a_count_bound, clk, rst_n, result_valid, count_ok)

    // one item at a time: the request side stalls right after taking an item
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, req_taken, request_stall)

endmodule

bind max_heap_priority_queue mhpq_checker #(
    .CAPACITY (CAPACITY)
) u_mhpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_value  (result_value),
    .status        (status),
    .entry_count   (entry_count)
);
